>>> sv/nrtc_pkg.sv
// Shared types, constants and helper functions for the NMEA RMC time checker.
// No dependencies; nrtc_line_parser and the core import this package.
`default_nettype none

package nrtc_pkg;

    localparam int unsigned HEADER_LEN = 6;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] CHAR_NINE   = 8'd57;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_V      = 8'h56;
    localparam logic [15:0] HEX_DIGIT_BIAS  = 16'd48;
    localparam logic [15:0] HEX_LETTER_BIAS = 16'd55;
    localparam logic [6:0] FIELD_DEAD  = 7'd100;
    localparam logic [4:0] ZONE_RESET  = 5'd8;

    localparam logic [7:0] HEADER_TEXT [HEADER_LEN] = '{
        8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43
    };

    // Outcome of a line, valid on the transaction that carries its final character
    typedef struct packed {
        logic       accepted;
        logic [6:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
    } t_line_verdict;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // One character into a two-character atoi-like time field
    function automatic logic [6:0] field_step(input logic [6:0] field,
                                              input logic [7:0] c,
                                              input logic       first);
        logic [7:0] dig;
        dig = c - CHAR_ZERO;
        if (first) begin
            return is_digit(c) ? {3'b000, dig[3:0]} : FIELD_DEAD;
        end
        if (field >= FIELD_DEAD) begin
            return FIELD_DEAD;
        end
        return is_digit(c) ? 7'(field * 7'd10) + {3'b000, dig[3:0]} : field;
    endfunction

    function automatic logic [6:0] field_value(input logic [6:0] field);
        return (field >= FIELD_DEAD) ? 7'd0 : field;
    endfunction

    // (hour field + zone) mod 24; the sum stays below 131
    function automatic logic [4:0] wrap_hour(input logic [6:0] hours,
                                             input logic [4:0] zone);
        logic [7:0] x;
        x = {1'b0, hours} + {3'b000, zone};
        if (x >= 8'd96) x = x - 8'd96;
        if (x >= 8'd48) x = x - 8'd48;
        if (x >= 8'd24) x = x - 8'd24;
        return x[4:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/nrtc_if.sv
// Channel interfaces of the NMEA RMC time checker: characters in, results out,
// and the zone offset write channel. Depends on nothing.
`default_nettype none

interface nrtc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       line_last;

    modport source (output valid, output char_byte, output line_last, input ready);
    modport sink   (input valid, input char_byte, input line_last, output ready);
endinterface

interface nrtc_result_if;
    logic       valid;
    logic       ready;
    logic       line_accepted;
    logic       time_known;
    logic [4:0] hour_out;
    logic [6:0] minute_out;
    logic [6:0] second_out;

    modport source (output valid, output line_accepted, output time_known,
                    output hour_out, output minute_out, output second_out,
                    input ready);
    modport sink   (input valid, input line_accepted, input time_known,
                    input hour_out, input minute_out, input second_out,
                    output ready);
endinterface

interface nrtc_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] zone_offset_hours;

    modport source (output valid, output zone_offset_hours, input ready);
    modport sink   (input valid, input zone_offset_hours, output ready);
endinterface

`default_nettype wire

>>> sv/nrtc_line_parser.sv
// Per-line sentence state: header match, status, XOR checksum, time fields.
// Depends on nrtc_pkg.
`default_nettype none

module nrtc_line_parser (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_take,
    input  wire logic [7:0]             i_char_byte,
    input  wire logic                   i_line_last,
    output nrtc_pkg::t_line_verdict     o_verdict
);
    import nrtc_pkg::*;

    logic [2:0]  r_pos,     n_pos;
    logic        r_hdr,     n_hdr;
    logic [1:0]  r_commas,  n_commas;
    logic        r_status,  n_status;
    logic        r_star,    n_star;
    logic [7:0]  r_xor,     n_xor;
    logic [15:0] r_sum,     n_sum;
    logic [2:0]  r_tidx,    n_tidx;
    logic [6:0]  r_hours,   n_hours;
    logic [6:0]  r_minutes, n_minutes;
    logic [6:0]  r_seconds, n_seconds;
    logic [15:0] hex_digit;
    logic        first;

    always_comb begin
        n_pos     = r_pos;
        n_hdr     = r_hdr;
        n_commas  = r_commas;
        n_status  = r_status;
        n_star    = r_star;
        n_xor     = r_xor;
        n_sum     = r_sum;
        n_tidx    = r_tidx;
        n_hours   = r_hours;
        n_minutes = r_minutes;
        n_seconds = r_seconds;
        first     = ~r_tidx[0];
        hex_digit = is_digit(i_char_byte) ? {8'd0, i_char_byte} - HEX_DIGIT_BIAS
                                          : {8'd0, i_char_byte} - HEX_LETTER_BIAS;

        if (r_pos < 3'(HEADER_LEN) && i_char_byte != HEADER_TEXT[r_pos]) begin
            n_hdr = 1'b0;
        end

        // everything after the first star feeds the received sum
        if (r_star) begin
            n_sum = {r_sum[11:0], 4'b0000} + hex_digit;
        end else if (i_char_byte == CHAR_STAR) begin
            n_star = 1'b1;
        end else if (r_pos != 3'd0) begin
            n_xor = r_xor ^ i_char_byte;
        end

        if (r_commas == 2'd2) begin
            n_status = (i_char_byte == CHAR_V);
            n_commas = 2'd3;
        end else if (r_commas < 2'd2 && i_char_byte == CHAR_COMMA) begin
            n_commas = r_commas + 2'd1;
        end

        if (r_commas != 2'd0 && r_tidx < 3'd6) begin
            if (r_tidx < 3'd2) begin
                n_hours = field_step(r_hours, i_char_byte, first);
            end else if (r_tidx < 3'd4) begin
                n_minutes = field_step(r_minutes, i_char_byte, first);
            end else begin
                n_seconds = field_step(r_seconds, i_char_byte, first);
            end
            n_tidx = r_tidx + 3'd1;
        end

        if (r_pos != 3'd7) begin
            n_pos = r_pos + 3'd1;
        end

        o_verdict.accepted = n_hdr && (n_pos >= 3'(HEADER_LEN)) && !n_status
                             && (n_sum == {8'd0, n_xor});
        o_verdict.hours    = field_value(n_hours);
        o_verdict.minutes  = field_value(n_minutes);
        o_verdict.seconds  = field_value(n_seconds);
    end

    always_ff @(posedge i_clk) begin
        // clear all per-line state after the final character
        if (!i_rst_n || (i_take && i_line_last)) begin
            r_pos     <= '0;
            r_hdr     <= 1'b1;
            r_commas  <= '0;
            r_status  <= 1'b0;
            r_star    <= 1'b0;
            r_xor     <= '0;
            r_sum     <= '0;
            r_tidx    <= '0;
            r_hours   <= '0;
            r_minutes <= '0;
            r_seconds <= '0;
        end else if (i_take) begin
            r_pos     <= n_pos;
            r_hdr     <= n_hdr;
            r_commas  <= n_commas;
            r_status  <= n_status;
            r_star    <= n_star;
            r_xor     <= n_xor;
            r_sum     <= n_sum;
            r_tidx    <= n_tidx;
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
        end
    end

endmodule

`default_nettype wire

>>> sv/nmea_rmc_time_checker_core.sv
// Top level of the NMEA RMC time checker: zone register, latched time, result register.
// Depends on nrtc_pkg, nrtc_if.sv and nrtc_line_parser.
//
//   channel   | dir | payload                                            | handshake
//   i_char    | in  | char_byte[7:0], line_last                          | valid/ready
//   o_result  | out | line_accepted, time_known, hour_out, minute_out,   | valid/ready
//             |     | second_out                                         |
//   i_cfg     | in  | zone_offset_hours[4:0]                             | valid/ready
//
// One character per cycle; each character updates the line state in the cycle
// it is taken, and the final character of a line loads the result register.
// i_char is ready whenever the result register is empty or being drained, so a
// stalled o_result holds new characters only while a result is still waiting.
// Reset sets the zone offset to 8, clears the latched time and the line state.
// i_cfg is always ready.
`default_nettype none

module nmea_rmc_time_checker_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    nrtc_char_if.sink   i_char,
    nrtc_result_if.source o_result,
    nrtc_cfg_if.sink    i_cfg
);
    import nrtc_pkg::*;

    logic          r_out_valid;
    logic          r_out_accepted;
    logic [4:0]    r_zone;
    logic [4:0]    r_hour,   n_hour;
    logic [6:0]    r_minute, n_minute;
    logic [6:0]    r_second, n_second;
    logic          r_known,  n_known;
    logic          take;
    logic          line_end;
    t_line_verdict verdict;

    assign i_char.ready = !r_out_valid || o_result.ready;
    assign i_cfg.ready  = 1'b1;
    assign take         = i_char.valid && i_char.ready;
    assign line_end     = take && i_char.line_last;

    nrtc_line_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_byte (i_char.char_byte),
        .i_line_last (i_char.line_last),
        .o_verdict   (verdict)
    );

    always_comb begin
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_known  = r_known;
        if (verdict.accepted) begin
            n_hour   = wrap_hour(verdict.hours, r_zone);
            n_minute = verdict.minutes;
            n_second = verdict.seconds;
            n_known  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_out_accepted <= 1'b0;
            r_zone         <= ZONE_RESET;
            r_hour         <= '0;
            r_minute       <= '0;
            r_second       <= '0;
            r_known        <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_zone <= i_cfg.zone_offset_hours;
            end
            if (line_end) begin
                r_out_valid    <= 1'b1;
                r_out_accepted <= verdict.accepted;
                r_hour         <= n_hour;
                r_minute       <= n_minute;
                r_second       <= n_second;
                r_known        <= n_known;
            end else if (o_result.ready) begin
                // drop the result once the transaction completes
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.line_accepted = r_out_accepted;
    assign o_result.time_known    = r_known;
    assign o_result.hour_out      = r_hour;
    assign o_result.minute_out    = r_minute;
    assign o_result.second_out    = r_second;

endmodule

`default_nettype wire
